// ----- src/sorted_priority_queue_assert.svh -----
// Assertion macros for the sorted priority queue.
// The macros sample on clk and are disabled while arst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define SPQ_ASSERT_NOW(lbl, pre, post, msg)

`define SPQ_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int CAPACITY_DEF  = 32;
	localparam int KEY_BITS_DEF  = 16;
	localparam int PRIO_BITS_DEF = 64;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_DEC = 2'd2,
		OP_QRY = 2'd3
	} spq_op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} spq_state_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic    apply;
		spq_op_t op;
	} spq_ctl_t;

endpackage

`default_nettype wire

// ----- src/spq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
	parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
	input  wire                    clk,
	input  spq_pkg::spq_ctl_t      ctl,
	input  wire                    occupied,
	input  wire  [KEY_BITS-1:0]    cmd_key,
	input  wire  [PRIO_BITS-1:0]   cmd_prio,
	input  wire  [KEY_BITS-1:0]    prev_key,
	input  wire  [PRIO_BITS-1:0]   prev_prio,
	input  wire                    prev_gt,
	input  wire  [KEY_BITS-1:0]    next_key,
	input  wire  [PRIO_BITS-1:0]   next_prio,
	input  wire                    seen_in,
	output logic [KEY_BITS-1:0]    key,
	output logic [PRIO_BITS-1:0]   prio,
	output logic                   gt,
	output logic                   seen_out,
	output logic                   improve
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0]  key_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [KEY_BITS-1:0]  key_d;
	logic [PRIO_BITS-1:0] prio_d;
	logic                 match;

	// empty cells count as greater so an insert lands at the tail
	assign gt       = occupied ? (prio_q > cmd_prio) : 1'b1;
	assign match    = occupied && (key_q == cmd_key);
	assign seen_out = seen_in | match;
	assign improve  = match & ~seen_in & gt;
	assign key      = key_q;
	assign prio     = prio_q;

	always_comb begin
		key_d  = key_q;
		prio_d = prio_q;
		case (ctl.op)
			OP_ENQ: begin
				if (prev_gt) begin
					key_d  = prev_key;
					prio_d = prev_prio;
				end else if (gt) begin
					key_d  = cmd_key;
					prio_d = cmd_prio;
				end
			end
			OP_DEQ: begin
				key_d  = next_key;
				prio_d = next_prio;
			end
			OP_DEC: begin
				// only cells up to and including the first match move
				if (!seen_in) begin
					if (prev_gt) begin
						key_d  = prev_key;
						prio_d = prev_prio;
					end else if (gt) begin
						key_d  = cmd_key;
						prio_d = cmd_prio;
					end
				end
			end
			default: begin
				key_d  = key_q;
				prio_d = prio_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			key_q  <= key_d;
			prio_q <= prio_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// Channel   Handshake              Ports
// command   start && !busy         action, item_key, item_priority
// result    done (one cycle)       ok, out_key, entry_count
//
// In a transaction the command is registered at the accepting edge and the row
// of cells compares and shifts at the next edge, which also loads the result
// registers. done is high the cycle after that, and busy is already low then,
// so a new command can be accepted while done is high, but none while busy.
// Reset clears the entry count and the control state; cell contents stay as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
	parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
	parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
	parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  [1:0]           action,
	input  wire  [KEY_BITS-1:0]  item_key,
	input  wire  [PRIO_BITS-1:0] item_priority,
	output logic                 done,
	output logic                 ok,
	output logic [KEY_BITS-1:0]  out_key,
	output logic [CNT_BITS-1:0]  entry_count
);
	import spq_pkg::*;

	spq_state_t           state_q;
	spq_state_t           state_d;
	spq_op_t              op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_d;
	logic                 done_q;
	logic                 ok_q;
	logic [KEY_BITS-1:0]  out_key_q;

	logic                 accept;
	logic                 exec;
	logic                 full;
	logic                 empty;
	logic                 upd_ok;
	logic                 ok_d;
	spq_ctl_t             ctl;

	logic [KEY_BITS-1:0]  cell_key  [CAPACITY];
	logic [PRIO_BITS-1:0] cell_prio [CAPACITY];
	logic [CAPACITY-1:0]  cell_gt;
	logic [CAPACITY-1:0]  cell_imp;
	logic [CAPACITY-1:0]  cell_occ;
	logic [CAPACITY:0]    seen;

	assign full   = (count_q == CNT_BITS'(CAPACITY));
	assign empty  = (count_q == '0);
	assign upd_ok = |cell_imp;
	assign seen[0] = 1'b0;

	// state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				exec = 1'b0;
			end
			ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= spq_op_t'(action);
			key_q  <= item_key;
			prio_q <= item_priority;
		end
	end

	// per-action enable and result
	always_comb begin
		ctl.op    = op_q;
		ctl.apply = 1'b0;
		ok_d      = 1'b0;
		count_d   = count_q;
		case (op_q)
			OP_ENQ: begin
				ok_d = !full;
				if (!full) count_d = count_q + CNT_BITS'(1);
			end
			OP_DEQ: begin
				ok_d = !empty;
				if (!empty) count_d = count_q - CNT_BITS'(1);
			end
			OP_DEC: begin
				ok_d = upd_ok;
			end
			OP_QRY: begin
				ok_d = seen[CAPACITY];
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		ctl.apply = exec && ok_d && (op_q != OP_QRY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			ok_q      <= ok_d;
			out_key_q <= (op_q == OP_DEQ && !empty) ? cell_key[0] : '0;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign out_key     = out_key_q;
	assign entry_count = count_q;

	// row of cells, head at index 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]  pk;
		logic [PRIO_BITS-1:0] pp;
		logic                 pg;
		logic [KEY_BITS-1:0]  nk;
		logic [PRIO_BITS-1:0] np;

		assign cell_occ[i] = (CNT_BITS'(i) < count_q);

		if (i == 0) begin : g_head
			assign pk = key_q;
			assign pp = prio_q;
			assign pg = 1'b0;
		end else begin : g_body
			assign pk = cell_key[i-1];
			assign pp = cell_prio[i-1];
			assign pg = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nk = cell_key[i];
			assign np = cell_prio[i];
		end else begin : g_mid
			assign nk = cell_key[i+1];
			assign np = cell_prio[i+1];
		end

		spq_cell #(
			.KEY_BITS (KEY_BITS),
			.PRIO_BITS(PRIO_BITS)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (cell_occ[i]),
			.cmd_key  (key_q),
			.cmd_prio (prio_q),
			.prev_key (pk),
			.prev_prio(pp),
			.prev_gt  (pg),
			.next_key (nk),
			.next_prio(np),
			.seen_in  (seen[i]),
			.key      (cell_key[i]),
			.prio     (cell_prio[i]),
			.gt       (cell_gt[i]),
			.seen_out (seen[i+1]),
			.improve  (cell_imp[i])
		);
	end

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_BITS'(CAPACITY), "entry count above capacity")
	`SPQ_ASSERT_NEXT(a_exec_done, state_q == ST_EXEC, done && !busy, "no result after execute cycle")
	`SPQ_ASSERT_NEXT(a_count_hold, state_q != ST_EXEC, $stable(count_q), "count moved without a transaction")
	`SPQ_ASSERT_NOW(a_upd_single, 1'b1, $onehot0(cell_imp), "more than one cell claims the update")

endmodule

`default_nettype wire
